// ===== rtl/core/vsfir_pkg.sv =====
// Package for the frequency-inversion voice scrambler.
// Holds the command codes, sequencer states and fixed field widths.
// No dependencies; imported by voice_scrambler_fir_mod_fir.
`timescale 1ns / 1ps
`default_nettype none

package vsfir_pkg;

  // Fixed field widths of the channels and the register.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 8;
  localparam int DATA_W  = 16;
  localparam int CFG_W   = 9;
  localparam int ACC_W   = 32;

  // Fixed-point scaling of the filter and modulator outputs.
  localparam int FIR_SHIFT = 15;
  localparam int MOD_SHIFT = 11;

  // Reset value of the sine length register.
  localparam logic [CFG_W-1:0] SINE_LEN_RESET = 9'd160;

  // Command codes carried with each input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_PROC      = 2'd0,
    CMD_LOAD_COEF = 2'd1,
    CMD_LOAD_SINE = 2'd2
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH,
    S_MAC,
    S_DRAIN,
    S_MOD_RD,
    S_MOD_MUL,
    S_MOD_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/vsfir_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the table store and the delay line store of the scrambler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vsfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/voice_scrambler_fir_mod_fir.sv =====
// Top level of the frequency-inversion voice scrambler: FIR, sine modulation, FIR.
// Depends on vsfir_pkg for codes and widths and on vsfir_ram for both stores.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   cmd, index, value
// output    out        out_valid / out_stall sample_out
// config    in         cfg_wen               cfg_wdata (sine length)
//
// For a process command, one shared multiplier walks four filter passes of TAPS
// taps, one delay line entry a cycle. Load commands and unused codes are taken
// in the idle state without leaving it. After reset a clearing pass zeroes all
// 2*TAPS entries of both delay lines; no input is taken meanwhile.
// The result sits in an output register, so the next input is taken while it waits;
// the sequencer only holds at the end of a sample if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module voice_scrambler_fir_mod_fir #(
  parameter int TAPS       = 64,
  parameter int SINE_DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [vsfir_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [vsfir_pkg::CMD_W-1:0]         cmd,
  input  wire logic [vsfir_pkg::INDEX_W-1:0]       index,
  input  wire logic signed [vsfir_pkg::DATA_W-1:0] value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [vsfir_pkg::DATA_W-1:0]      sample_out
);

  import vsfir_pkg::*;

  localparam int PW  = $clog2(TAPS);
  localparam int SW  = $clog2(SINE_DEPTH);
  localparam int DAW = $clog2(2 * TAPS);
  localparam int TAW = $clog2(TAPS + SINE_DEPTH);

  localparam logic [PW-1:0]    TAP_LAST  = PW'(TAPS - 1);
  localparam logic [DAW-1:0]   CLR_LAST  = DAW'(2 * TAPS - 1);
  localparam logic [CFG_W-1:0] TAPS_LIM  = CFG_W'(TAPS);
  localparam logic [CFG_W-1:0] SINE_LIM  = CFG_W'(SINE_DEPTH);
  localparam logic [TAW-1:0]   SINE_BASE = TAW'(TAPS);
  localparam logic [DAW-1:0]   LINE_BASE = DAW'(TAPS);

  // Registers.
  state_t                    state, state_next;
  logic [CFG_W-1:0]          sine_length;
  logic [SW-1:0]             phase;
  logic [PW-1:0]             head;
  logic [PW-1:0]             rd_ptr;
  logic [PW-1:0]             tap;
  logic [DAW-1:0]            clr_cnt;
  logic [1:0]                pass;
  logic                      v1;
  logic                      v2;
  logic signed [DATA_W-1:0]  sample;
  logic signed [DATA_W-1:0]  opnd;
  logic signed [ACC_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc;

  // Memory ports.
  logic                      tab_we;
  logic [TAW-1:0]            tab_waddr;
  logic [TAW-1:0]            tab_raddr;
  logic [DATA_W-1:0]         tab_rdata;
  logic                      dly_we;
  logic [DAW-1:0]            dly_waddr;
  logic [DATA_W-1:0]         dly_wdata;
  logic [DAW-1:0]            dly_raddr;
  logic [DATA_W-1:0]         dly_rdata;

  // Combinational helpers.
  logic                      in_xfer;
  logic                      issue;
  logic                      pipe_empty;
  logic                      out_free;
  logic                      line_sel;
  logic signed [DATA_W-1:0]  fir_y;
  logic signed [DATA_W-1:0]  mul_a;
  logic [CFG_W-1:0]          len_eff;
  logic [CFG_W-1:0]          phase_inc;
  logic [PW-1:0]             head_inc;

  assign in_xfer    = in_valid && !in_stall;
  assign pipe_empty = !v1 && !v2;
  assign out_free   = !out_valid || !out_stall;
  assign line_sel   = pass[0];
  assign fir_y      = acc[FIR_SHIFT+DATA_W-1:FIR_SHIFT];
  assign head_inc   = (head == TAP_LAST) ? '0 : head + 1'b1;

  // Effective sine length: zero acts as one, large values clip to the table.
  always_comb begin
    if (sine_length == '0) begin
      len_eff = CFG_W'(1);
    end else if (sine_length > SINE_LIM) begin
      len_eff = SINE_LIM;
    end else begin
      len_eff = sine_length;
    end
    phase_inc = CFG_W'(phase) + 1'b1;
  end

  // Table store: coefficients first, then the sine entries.
  vsfir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TAPS + SINE_DEPTH)
  ) u_tab_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (value),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // Delay store: first line, then second line, both circular around head.
  vsfir_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 * TAPS)
  ) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wdata),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    issue      = 1'b0;
    tab_we     = 1'b0;
    tab_waddr  = '0;
    tab_raddr  = TAW'(tap);
    dly_we     = 1'b0;
    dly_waddr  = line_sel ? LINE_BASE + DAW'(head) : DAW'(head);
    dly_wdata  = opnd;
    dly_raddr  = line_sel ? LINE_BASE + DAW'(rd_ptr) : DAW'(rd_ptr);
    case (state)
      S_CLEAR: begin
        dly_we    = 1'b1;
        dly_waddr = clr_cnt;
        dly_wdata = '0;
        if (clr_cnt == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (cmd)
            CMD_PROC: begin
              state_next = S_PUSH;
            end
            CMD_LOAD_COEF: begin
              tab_we    = (CFG_W'(index) < TAPS_LIM);
              tab_waddr = TAW'(index[PW-1:0]);
            end
            CMD_LOAD_SINE: begin
              tab_we    = (CFG_W'(index) < SINE_LIM);
              tab_waddr = SINE_BASE + TAW'(index[SW-1:0]);
            end
            default: begin
            end
          endcase
        end
      end
      S_PUSH: begin
        dly_we     = 1'b1;
        state_next = S_MAC;
      end
      S_MAC: begin
        issue = 1'b1;
        if (tap == TAP_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (pipe_empty) begin
          if (!line_sel) begin
            state_next = S_MOD_RD;
          end else if (pass == 2'd1) begin
            state_next = S_PUSH;
          end else if (out_free) begin
            state_next = S_IDLE;
          end
        end
      end
      S_MOD_RD: begin
        tab_raddr  = SINE_BASE + TAW'(phase);
        state_next = S_MOD_MUL;
      end
      S_MOD_MUL: begin
        state_next = S_MOD_FIN;
      end
      S_MOD_FIN: begin
        state_next = S_PUSH;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Shared multiplier: delay sample by coefficient, or filter output by sine.
  assign mul_a = (state == S_MOD_MUL) ? opnd : $signed(dly_rdata);

  always_ff @(posedge clk) begin
    prod <= mul_a * $signed(tab_rdata);
  end

  // Multiply-accumulate pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // Control counters and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      head    <= '0;
      phase   <= '0;
      pass    <= '0;
      tap     <= '0;
      rd_ptr  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        S_IDLE: begin
          pass <= 2'd0;
        end
        S_PUSH: begin
          tap    <= '0;
          rd_ptr <= head;
        end
        S_MAC: begin
          tap    <= tap + 1'b1;
          rd_ptr <= (rd_ptr == '0) ? TAP_LAST : rd_ptr - 1'b1;
        end
        S_DRAIN: begin
          if (pipe_empty && line_sel && (pass == 2'd1 || out_free)) begin
            head <= head_inc;
            pass <= pass + 1'b1;
          end
        end
        S_MOD_MUL: begin
          phase <= (phase_inc >= len_eff) ? '0 : phase_inc[SW-1:0];
        end
        S_MOD_FIN: begin
          pass <= pass + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: held sample, stage operand and accumulator.
  always_ff @(posedge clk) begin
    if (in_xfer && cmd == CMD_PROC) begin
      sample <= value;
      opnd   <= value;
    end
    if (state == S_PUSH) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
    if (state == S_DRAIN && pipe_empty) begin
      opnd <= line_sel ? sample : fir_y;
    end
    if (state == S_MOD_FIN) begin
      opnd <= prod[MOD_SHIFT+DATA_W-1:MOD_SHIFT];
    end
  end

  // Sine length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sine_length <= SINE_LEN_RESET;
    end else if (cfg_wen) begin
      sine_length <= cfg_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DRAIN && pipe_empty && pass == 2'd3 && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DRAIN && pipe_empty && pass == 2'd3 && out_free) begin
      sample_out <= fir_y;
    end
  end

  // A new result only appears at the end of the fourth filter pass.
  a_out_from_last_pass : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DRAIN && $past(pass) == 2'd3))
    else $error("result raised outside the final filter pass");

  // A filter pass ends only once the accumulate pipeline has emptied.
  a_drain_complete : assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && state_next != S_DRAIN) |-> (!v1 && !v2))
    else $error("filter pass left with products still in flight");

  // An accepted process command starts by pushing into the first delay line.
  a_proc_starts : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && cmd == CMD_PROC) |=> (state == S_PUSH && pass == 2'd0))
    else $error("process command did not start the first filter pass");

  // The phase index always addresses an entry inside the sine table.
  a_phase_range : assert property (@(posedge clk) disable iff (rst)
    CFG_W'(phase) < SINE_LIM)
    else $error("phase index outside the sine table");

endmodule

`default_nettype wire
